@@ hw/rtl/hcbp_pkg.sv @@
package hcbp_pkg;

    localparam int CODE_W           = 32;
    localparam int CODE_IDX_W       = $clog2(CODE_W);
    localparam int SYM_W            = 8;
    localparam int LEN_IN_W         = 6;
    localparam int BYTE_W           = 8;
    localparam int CNT_W            = $clog2(BYTE_W);
    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOL_COUNT = 256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_FLUSH
    } t_state;

    // One code bit offered to the packer.
    typedef struct packed {
        logic valid;
        logic data;
        logic last;
    } t_bit_in;

    // Packer status back to the sequencer.
    typedef struct packed {
        logic ready;
        logic empty;
        logic full7;
    } t_pack_st;

endpackage

@@ hw/rtl/hcbp_code_store.sv @@
module hcbp_code_store #(
    parameter int DEPTH  = hcbp_pkg::DEF_SYMBOL_COUNT,
    parameter int ADDR_W = $clog2(hcbp_pkg::DEF_SYMBOL_COUNT),
    parameter int DATA_W = hcbp_pkg::CODE_W + 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/hcbp_packer.sv @@
module hcbp_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hcbp_pkg::t_bit_in  i_bit,
    output hcbp_pkg::t_pack_st o_st,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast
);
    import hcbp_pkg::*;

    logic [BYTE_W-2:0] r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;
    logic              w_byte_done;
    logic              w_ready;
    logic              w_take;

    // The bit that completes a byte can only be taken when the output register frees up.
    assign w_byte_done = (r_cnt == CNT_W'(BYTE_W - 1));
    assign w_ready     = !w_byte_done || !r_out_valid || i_m_tready;
    assign w_take      = i_bit.valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_cnt <= w_byte_done ? '0 : CNT_W'(r_cnt + 1'b1);
            end
            if (w_take && w_byte_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_acc <= {r_acc[BYTE_W-3:0], i_bit.data};
        end
        if (w_take && w_byte_done) begin
            r_out_data <= {r_acc, i_bit.data};
            r_out_last <= i_bit.last;
        end
    end

    assign o_st.ready  = w_ready;
    assign o_st.empty  = (r_cnt == '0);
    assign o_st.full7  = w_byte_done;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tlast   = r_out_last;

endmodule

@@ hw/rtl/huffman_code_bit_packer.sv @@
// Huffman encoder back end: code table plus MSB-first bit packer.
// Input words arrive on the slave stream. tuser carries the operation
// (load entry, encode symbol, flush); tdata carries symbol, code bits and
// code length. Output words on the master stream are packed bytes, the
// earliest code bit in bit 7, with tlast on the final byte of each input word.
// An encode first reads the table entry, then the packer shifts one bit
// per cycle while the output side does not stall it, so the code length
// sets the symbol rate. A flush with bits pending shifts in zero bits until
// the byte is complete; with nothing pending it yields no byte. A byte
// appears on the master side the cycle after its eighth bit enters the
// packer. A finished byte waits in the output register while the next bits
// gather; if the receiver stalls and a second byte completes, the shifter holds.
// Reset (synchronous, active low) empties the bit buffer and the output
// register. Table entries are undefined until loaded.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // symbol[7:0], code_bits[39:8], code_length[45:40]
    input  logic [1:0]  i_s_tuser,  // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // out_byte[7:0]
    output logic        o_m_tlast
);
    import hcbp_pkg::*;

    localparam int LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LEN_W   = $clog2(LIMIT + 1);
    localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W = CODE_W + LEN_W;

    t_state             r_state;
    t_state             n_state;
    logic [CODE_W-1:0]  r_code;
    logic [LEN_W-1:0]   r_rem;
    logic [LEN_W-1:0]   n_rem;

    logic               w_accept;
    t_op                w_op;
    logic [SYM_W-1:0]   w_sym;
    logic [CODE_W-1:0]  w_code;
    logic [LEN_IN_W-1:0] w_len;
    logic [LEN_W-1:0]   w_len_sat;
    logic               w_sym_ok;
    logic               w_we;
    logic [ENTRY_W-1:0] w_rdata;
    logic [LEN_W-1:0]   w_rd_len;
    logic [CODE_IDX_W-1:0] w_idx;
    t_bit_in            w_bit;
    t_pack_st           w_st;

    assign w_op   = t_op'(i_s_tuser);
    assign w_sym  = i_s_tdata[7:0];
    assign w_code = i_s_tdata[39:8];
    assign w_len  = i_s_tdata[45:40];

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_sym_ok  = ({1'b0, w_sym} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign w_len_sat = (w_len > LEN_IN_W'(LIMIT)) ? LEN_W'(LIMIT) : LEN_W'(w_len);
    assign w_we      = w_accept && (w_op == OP_LOAD) && w_sym_ok;
    assign w_rd_len  = w_rdata[ENTRY_W-1:CODE_W];
    assign w_idx     = CODE_IDX_W'(r_rem - LEN_W'(1));

    hcbp_code_store #(
        .DEPTH  (SYMBOL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_sym[ADDR_W-1:0]),
        .i_wdata ({w_len_sat, w_code}),
        .i_raddr (w_sym[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    hcbp_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bit      (w_bit),
        .o_st       (w_st),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_ENCODE: begin
                            if (w_sym_ok) begin
                                n_state = S_READ;
                            end
                        end
                        OP_FLUSH: begin
                            if (!w_st.empty) begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                n_state = (w_rd_len == '0) ? S_IDLE : S_SHIFT;
            end
            S_SHIFT: begin
                if (w_st.ready && (r_rem == LEN_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_st.ready && w_st.full7) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_bit      = '0;
        n_rem      = r_rem;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_READ: begin
                n_rem = w_rd_len;
            end
            S_SHIFT: begin
                // A byte is the last of this symbol when fewer than eight bits follow it.
                w_bit.valid = 1'b1;
                w_bit.data  = r_code[w_idx];
                w_bit.last  = (r_rem <= LEN_W'(8));
                if (w_st.ready) begin
                    n_rem = LEN_W'(r_rem - LEN_W'(1));
                end
            end
            S_FLUSH: begin
                w_bit.valid = 1'b1;
                w_bit.data  = 1'b0;
                w_bit.last  = 1'b1;
            end
            default: n_rem = r_rem;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_code <= w_rdata[CODE_W-1:0];
        end
    end

`ifndef ASSERT_OFF
    a_shift_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_rem != '0))
        else $error("shift state entered with no code bits left");

    a_flush_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> !w_st.empty)
        else $error("flush running with an empty bit buffer");

    a_encode_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_ENCODE) && w_sym_ok) |=> (r_state == S_READ))
        else $error("encode word did not start a table read");

    a_idle_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) || (r_state == S_READ)) |-> !w_bit.valid)
        else $error("bit offered to the packer outside shift or flush");
`endif

endmodule
